// ----- rtl/rrbs_pkg.sv -----
// Shared constants for the round-robin broadcast scheduler.
// Holds default sizes, function codes and status codes; no dependencies.
package rrbs_pkg;

    localparam int RRBS_MAX_REQUESTS     = 16;
    localparam int RRBS_MAX_DESTINATIONS = 16;

    // Function codes of an input word
    localparam logic [1:0] FN_ADD      = 2'd0;
    localparam logic [1:0] FN_REMOVE   = 2'd1;
    localparam logic [1:0] FN_SERVE    = 2'd2;
    localparam logic [1:0] FN_RESERVED = 2'd3;   // no operation, reports a miss

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

endpackage

// ----- rtl/round_robin_broadcast_scheduler.sv -----
// Round-robin broadcast scheduler: request ring, slot and destination memories.
// Single module; depends on rrbs_pkg.
//
// Broadcast requests wait in a ring of up to MAX_REQUESTS slots, each holding a
// request id, a packet handle and a circular queue of up to MAX_DESTINATIONS
// destination ids. Add words (func 0) stream destinations into the request under
// construction; the word with last_destination set appends it to the ring tail.
// Remove (func 1) deletes the first ring entry whose id matches and compacts the
// ring. Serve (func 2) pops the ring head, returns its front destination and
// requeues the request at the tail while destinations remain. Every word yields
// exactly one result word carrying the pending destination total (saturated at
// 511). Request ids, packet handles, destinations and ring order live in
// synchronous memories with registered reads; per-slot queue head and
// count and the slot-in-use mask are flops cleared by reset, so there is no
// clearing pass after reset. One word is processed at a time. Add steps
// through S_ADD; serve through S_SV_ORD and S_SV_DAT (ring order read, then
// slot data read). Remove steps through S_RM_ORD and S_RM_CMP (ring read,
// then id read) per ring entry probed up to the match, then S_RM_SHW per
// entry shifted down behind it. Serve or remove on an empty ring and an
// unused func go straight to S_RESP. The result sits in an output register,
// so the next word is taken while the previous result still waits for i_ready.
module round_robin_broadcast_scheduler
    import rrbs_pkg::*;
#(
    parameter int MAX_REQUESTS     = RRBS_MAX_REQUESTS,
    parameter int MAX_DESTINATIONS = RRBS_MAX_DESTINATIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_request_id,
    input  logic [15:0] i_packet_handle,
    input  logic [7:0]  i_destination_id,
    input  logic        i_last_destination,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_served_request_id,
    output logic [15:0] o_served_packet,
    output logic [7:0]  o_served_destination,
    output logic [8:0]  o_pending_count
);

    localparam int R   = MAX_REQUESTS;
    localparam int D   = MAX_DESTINATIONS;
    localparam int SW  = $clog2(R);                  // slot index
    localparam int CW  = $clog2(R + 1);              // ring count
    localparam int DW  = (D > 1) ? $clog2(D) : 1;    // queue head
    localparam int DCW = $clog2(D + 1);              // queue count
    localparam int AW  = $clog2(R * D);              // destination store address
    localparam int PW  = $clog2(R * D + 1);          // pending total

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_RM_ORD, S_RM_CMP, S_RM_SHW, S_SV_ORD, S_SV_DAT, S_RESP
    } t_state;

    function automatic logic [SW-1:0] ring_pos(input logic [SW-1:0] h,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(h) + (CW+1)'(off);
        if (sum >= (CW+1)'(R))
            sum = sum - (CW+1)'(R);
        return SW'(sum);
    endfunction

    function automatic logic [AW-1:0] dest_addr(input logic [SW-1:0] s,
                                                input logic [DW-1:0] p);
        return AW'(32'(s) * D + 32'(p));
    endfunction

    // Control and result registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_p, n_p;
    logic [SW-1:0]   r_slot, n_slot;
    logic [SW-1:0]   r_ring_head, n_ring_head;
    logic [CW-1:0]   r_ring_cnt, n_ring_cnt;
    logic [R-1:0]    r_in_use, n_in_use;
    logic [PW-1:0]   r_pending, n_pending;
    logic            r_bact, n_bact;
    logic            r_bovf, n_bovf;
    logic [SW-1:0]   r_bslot, n_bslot;
    logic [31:0]     r_id, n_id;
    logic [15:0]     r_pkt, n_pkt;
    logic [7:0]      r_dst, n_dst;
    logic            r_last, n_last;
    logic [1:0]      r_res_status, n_res_status;
    logic [31:0]     r_res_rid, n_res_rid;
    logic [15:0]     r_res_pkt, n_res_pkt;
    logic [7:0]      r_res_dst, n_res_dst;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_o_status, n_o_status;
    logic [31:0]     r_o_rid, n_o_rid;
    logic [15:0]     r_o_pkt, n_o_pkt;
    logic [7:0]      r_o_dst, n_o_dst;
    logic [8:0]      r_o_pend, n_o_pend;

    // Per-slot queue pointers (reset to zero)
    logic [DW-1:0]   r_slot_head [R];
    logic [DCW-1:0]  r_slot_cnt  [R];
    logic            hc_we;
    logic [SW-1:0]   hc_idx;
    logic [DW-1:0]   hc_head;
    logic [DCW-1:0]  hc_cnt;

    // Memories
    logic [SW-1:0]   ring_mem [R];
    logic [31:0]     id_mem   [R];
    logic [15:0]     pkt_mem  [R];
    logic [7:0]      dest_mem [R*D];
    logic            ring_we, slot_we, dest_we;
    logic [SW-1:0]   ring_wa, ring_wd, ring_ra, ring_rd;
    logic [SW-1:0]   slot_wa, slot_ra;
    logic [31:0]     id_rd;
    logic [15:0]     pkt_rd;
    logic [AW-1:0]   dest_wa, dest_ra;
    logic [7:0]      dest_rd;

    // Free slot search
    logic            free_found;
    logic [SW-1:0]   free_slot;

    // Working values
    logic [SW-1:0]   a_slot;
    logic            a_ovf;
    logic [DCW-1:0]  a_cnt;
    logic [DW-1:0]   a_head;
    logic [DCW:0]    a_sum;
    logic [CW-1:0]   p1, p2;
    logic            rm_finish;
    logic [DW-1:0]   sv_h, sv_hn;
    logic [DCW-1:0]  sv_c, sv_cn;
    logic [SW-1:0]   sv_nh;
    logic [CW-1:0]   sv_nc;

    assign o_ready              = (r_state == S_IDLE);
    assign o_valid              = r_out_valid;
    assign o_status             = r_o_status;
    assign o_served_request_id  = r_o_rid;
    assign o_served_packet      = r_o_pkt;
    assign o_served_destination = r_o_dst;
    assign o_pending_count      = r_o_pend;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = R - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_p          = r_p;
        n_slot       = r_slot;
        n_ring_head  = r_ring_head;
        n_ring_cnt   = r_ring_cnt;
        n_in_use     = r_in_use;
        n_pending    = r_pending;
        n_bact       = r_bact;
        n_bovf       = r_bovf;
        n_bslot      = r_bslot;
        n_id         = r_id;
        n_pkt        = r_pkt;
        n_dst        = r_dst;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_rid    = r_res_rid;
        n_res_pkt    = r_res_pkt;
        n_res_dst    = r_res_dst;
        n_out_valid  = r_out_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_rid      = r_o_rid;
        n_o_pkt      = r_o_pkt;
        n_o_dst      = r_o_dst;
        n_o_pend     = r_o_pend;
        hc_we = 1'b0;  hc_idx = r_slot;  hc_head = '0;  hc_cnt = '0;
        ring_we = 1'b0;  ring_wa = '0;  ring_wd = '0;  ring_ra = r_ring_head;
        slot_we = 1'b0;  slot_wa = '0;  slot_ra = r_slot;
        dest_we = 1'b0;  dest_wa = '0;  dest_ra = '0;
        a_slot = r_bslot;  a_ovf = r_bovf;
        a_cnt  = r_slot_cnt[r_bslot];  a_head = r_slot_head[r_bslot];  a_sum = '0;
        p1 = r_p + 1'b1;
        p2 = p1 + 1'b1;
        rm_finish = 1'b0;
        sv_h  = r_slot_head[r_slot];
        sv_hn = '0;
        sv_c  = r_slot_cnt[r_slot];
        sv_cn = sv_c;
        sv_nh = '0;
        sv_nc = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_id         = i_request_id;
                    n_pkt        = i_packet_handle;
                    n_dst        = i_destination_id;
                    n_last       = i_last_destination;
                    n_p          = '0;
                    n_res_status = ST_MISS;
                    n_res_rid    = '0;
                    n_res_pkt    = '0;
                    n_res_dst    = '0;
                    case (i_func)
                        FN_ADD: n_state = S_ADD;
                        FN_REMOVE: begin
                            ring_ra = r_ring_head;
                            n_state = (r_ring_cnt != '0) ? S_RM_ORD : S_RESP;
                        end
                        FN_SERVE: begin
                            ring_ra = r_ring_head;
                            n_state = (r_ring_cnt != '0) ? S_SV_ORD : S_RESP;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end

            S_ADD: begin
                n_bact = 1'b1;
                if (!r_bact) begin
                    if (free_found) begin
                        a_slot  = free_slot;
                        a_ovf   = 1'b0;
                        a_cnt   = '0;
                        a_head  = '0;
                        n_bslot = free_slot;
                        n_in_use[free_slot] = 1'b1;
                        slot_we = 1'b1;
                        slot_wa = free_slot;
                    end else begin
                        a_ovf = 1'b1;
                    end
                end
                if (a_ovf) begin
                    n_bovf       = 1'b1;
                    n_res_status = ST_FULL;
                end else if (32'(a_cnt) >= D) begin
                    // queue full: drop the request under construction
                    n_in_use[a_slot] = 1'b0;
                    n_bovf           = 1'b1;
                    n_res_status     = ST_FULL;
                end else begin
                    a_sum = (DCW+1)'(a_head) + (DCW+1)'(a_cnt);
                    if (32'(a_sum) >= D)
                        a_sum = a_sum - (DCW+1)'(D);
                    dest_we = 1'b1;
                    dest_wa = dest_addr(a_slot, DW'(a_sum));
                    hc_we   = 1'b1;
                    hc_idx  = a_slot;
                    hc_head = a_head;
                    hc_cnt  = a_cnt + 1'b1;
                    n_bovf  = 1'b0;
                    n_res_status = ST_OK;
                    if (r_last) begin
                        if (32'(r_ring_cnt) < R) begin
                            ring_we    = 1'b1;
                            ring_wa    = ring_pos(r_ring_head, r_ring_cnt);
                            ring_wd    = a_slot;
                            n_ring_cnt = r_ring_cnt + 1'b1;
                        end
                        n_pending = r_pending + PW'(a_cnt + 1'b1);
                    end
                end
                if (r_last) begin
                    n_bact = 1'b0;
                    n_bovf = 1'b0;
                end
                n_state = S_RESP;
            end

            S_RM_ORD: begin
                n_slot  = ring_rd;
                slot_ra = ring_rd;
                n_state = S_RM_CMP;
            end

            S_RM_CMP: begin
                if (id_rd == r_id) begin
                    if (p1 < r_ring_cnt) begin
                        ring_ra = ring_pos(r_ring_head, p1);
                        n_state = S_RM_SHW;
                    end else begin
                        rm_finish = 1'b1;
                    end
                end else begin
                    n_p = p1;
                    if (p1 < r_ring_cnt) begin
                        ring_ra = ring_pos(r_ring_head, p1);
                        n_state = S_RM_ORD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end

            S_RM_SHW: begin
                // move entry p+1 down to p, fetch the next one behind it
                ring_we = 1'b1;
                ring_wa = ring_pos(r_ring_head, r_p);
                ring_wd = ring_rd;
                n_p     = p1;
                if (p2 < r_ring_cnt)
                    ring_ra = ring_pos(r_ring_head, p2);
                else
                    rm_finish = 1'b1;
            end

            S_SV_ORD: begin
                n_slot  = ring_rd;
                slot_ra = ring_rd;
                dest_ra = dest_addr(ring_rd, r_slot_head[ring_rd]);
                n_state = S_SV_DAT;
            end

            S_SV_DAT: begin
                n_res_rid    = id_rd;
                n_res_pkt    = pkt_rd;
                n_res_dst    = dest_rd;
                n_res_status = ST_OK;
                sv_hn = (32'(sv_h) >= D - 1) ? '0 : sv_h + 1'b1;
                if (sv_c != '0)
                    sv_cn = sv_c - 1'b1;
                hc_we   = 1'b1;
                hc_idx  = r_slot;
                hc_head = sv_hn;
                hc_cnt  = sv_cn;
                sv_nh = (32'(r_ring_head) >= R - 1) ? '0 : r_ring_head + 1'b1;
                sv_nc = r_ring_cnt - 1'b1;
                n_ring_head = sv_nh;
                n_ring_cnt  = sv_nc;
                if (sv_cn == '0) begin
                    n_in_use[r_slot] = 1'b0;
                end else if (32'(sv_nc) < R) begin
                    ring_we    = 1'b1;
                    ring_wa    = ring_pos(sv_nh, sv_nc);
                    ring_wd    = r_slot;
                    n_ring_cnt = sv_nc + 1'b1;
                end
                if (r_pending != '0)
                    n_pending = r_pending - 1'b1;
                n_state = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_rid     = r_res_rid;
                    n_o_pkt     = r_res_pkt;
                    n_o_dst     = r_res_dst;
                    n_o_pend    = (32'(r_pending) > 511) ? 9'd511 : 9'(r_pending);
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (rm_finish) begin
            n_ring_cnt = r_ring_cnt - 1'b1;
            n_pending  = (r_pending >= PW'(r_slot_cnt[r_slot]))
                         ? r_pending - PW'(r_slot_cnt[r_slot]) : '0;
            hc_we   = 1'b1;
            hc_idx  = r_slot;
            hc_head = r_slot_head[r_slot];
            hc_cnt  = '0;
            n_in_use[r_slot] = 1'b0;
            n_res_status     = ST_OK;
            n_state          = S_RESP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p         <= '0;
            r_slot      <= '0;
            r_ring_head <= '0;
            r_ring_cnt  <= '0;
            r_in_use    <= '0;
            r_pending   <= '0;
            r_bact      <= 1'b0;
            r_bovf      <= 1'b0;
            r_bslot     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < R; i++) begin
                r_slot_head[i] <= '0;
                r_slot_cnt[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_slot      <= n_slot;
            r_ring_head <= n_ring_head;
            r_ring_cnt  <= n_ring_cnt;
            r_in_use    <= n_in_use;
            r_pending   <= n_pending;
            r_bact      <= n_bact;
            r_bovf      <= n_bovf;
            r_bslot     <= n_bslot;
            r_out_valid <= n_out_valid;
            if (hc_we) begin
                r_slot_head[hc_idx] <= hc_head;
                r_slot_cnt[hc_idx]  <= hc_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_pkt        <= n_pkt;
        r_dst        <= n_dst;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_rid    <= n_res_rid;
        r_res_pkt    <= n_res_pkt;
        r_res_dst    <= n_res_dst;
        r_o_status   <= n_o_status;
        r_o_rid      <= n_o_rid;
        r_o_pkt      <= n_o_pkt;
        r_o_dst      <= n_o_dst;
        r_o_pend     <= n_o_pend;
    end

    always_ff @(posedge i_clk) begin
        if (ring_we)
            ring_mem[ring_wa] <= ring_wd;
        ring_rd <= ring_mem[ring_ra];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            id_mem[slot_wa]  <= r_id;
            pkt_mem[slot_wa] <= r_pkt;
        end
        id_rd  <= id_mem[slot_ra];
        pkt_rd <= pkt_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dest_we)
            dest_mem[dest_wa] <= r_dst;
        dest_rd <= dest_mem[dest_ra];
    end

`ifndef NO_ASSERTIONS
    // the ring holds no more entries than there are slots in use
    a_ring_vs_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ring_cnt) <= $countones(r_in_use))
        else $error("ring holds more entries than slots in use");

    // a request under construction owns its slot
    a_build_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bact && !r_bovf && r_state == S_IDLE) |-> r_in_use[r_bslot])
        else $error("building request lost its slot");

    // compaction only runs inside the ring
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RM_SHW) |-> (p1 < r_ring_cnt))
        else $error("ring compaction beyond ring tail");

    // a new result is only loaded into a free or draining output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_ready) |=> r_state == S_RESP)
        else $error("result overwrote a waiting word");
`endif

endmodule
